// ===== hdl/sahl_pkg.sv =====
// Shared types, codes and the key hash for the SA hash table lookup unit.
// No dependencies; every other file except sahl_ram imports this package.
`timescale 1ns / 1ps

package sahl_pkg;

   localparam int COOKIE_W = 64;
   localparam int MID_W    = 32;
   localparam int HANDLE_W = 16;
   localparam int WORD_W   = 16;   // hash folds the key in 16-bit words

   typedef logic [1:0] op_type;
   localparam op_type OP_INSERT = 2'd0;
   localparam op_type OP_LOOKUP = 2'd1;
   localparam op_type OP_REMOVE = 2'd2;

   typedef logic [1:0] status_type;
   localparam status_type STATUS_OK        = 2'd0;
   localparam status_type STATUS_NOT_FOUND = 2'd1;
   localparam status_type STATUS_FULL      = 2'd2;
   localparam status_type STATUS_ABSENT    = 2'd3;

   typedef struct packed {
      logic [COOKIE_W-1:0] initiator_cookie;
      logic [COOKIE_W-1:0] responder_cookie;
      logic [MID_W-1:0]    msg_id;
      logic [HANDLE_W-1:0] handle;
   } entry_type;

   localparam int ENTRY_W = $bits(entry_type);

   typedef enum logic {
      S_IDLE,
      S_EXEC
   } state_type;

   // controller -> datapath
   typedef struct packed {
      logic load;     // capture request, start bucket row read
      logic commit;   // update bucket, load result register
   } dp_cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic out_blocked;  // result register holds an item not yet taken
   } dp_stat_type;

   // XOR of the little-endian 16-bit words of both cookies, and of msg_id when use_mid is set
   function automatic logic [WORD_W-1:0] fold_key(
      input logic [COOKIE_W-1:0] ic,
      input logic [COOKIE_W-1:0] rc,
      input logic [MID_W-1:0]    mid,
      input logic                use_mid
   );
      logic [WORD_W-1:0] acc;
      acc = '0;
      for (int i = 0; i < COOKIE_W / WORD_W; i++) begin
         acc = acc ^ ic[i*WORD_W +: WORD_W] ^ rc[i*WORD_W +: WORD_W];
      end
      if (use_mid) begin
         for (int i = 0; i < MID_W / WORD_W; i++) begin
            acc = acc ^ mid[i*WORD_W +: WORD_W];
         end
      end
      return acc;
   endfunction

endpackage

// ===== hdl/sahl_if.sv =====
// Request and response channel interfaces (valid/ready plus payload).
// Depends on sahl_pkg.
`timescale 1ns / 1ps

interface sahl_req_if import sahl_pkg::*; ();
   logic                valid;
   logic                ready;
   op_type              op;
   logic [COOKIE_W-1:0] initiator_cookie;
   logic [COOKIE_W-1:0] responder_cookie;
   logic [MID_W-1:0]    msg_id;
   logic                match_msg_id;
   logic [HANDLE_W-1:0] entry_handle;

   modport source (
      output valid, op, initiator_cookie, responder_cookie, msg_id,
             match_msg_id, entry_handle,
      input  ready
   );
   modport sink (
      input  valid, op, initiator_cookie, responder_cookie, msg_id,
             match_msg_id, entry_handle,
      output ready
   );
endinterface

interface sahl_rsp_if import sahl_pkg::*; ();
   logic                valid;
   logic                ready;
   status_type          status;
   logic [HANDLE_W-1:0] found_handle;

   modport source (
      output valid, status, found_handle,
      input  ready
   );
   modport sink (
      input  valid, status, found_handle,
      output ready
   );
endinterface

// ===== hdl/sahl_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module sahl_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== hdl/sahl_ctrl.sv =====
// Controller for the SA hash table lookup unit: accept, then execute.
// Depends on sahl_pkg.
`timescale 1ns / 1ps

module sahl_ctrl import sahl_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   output dp_cmd_type  cmd,
   input  dp_stat_type stat
);

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) state_in = S_EXEC;
         end
         S_EXEC: begin
            if (!stat.out_blocked) state_in = S_IDLE;
         end
      endcase
   end

   always_comb begin
      req_ready  = 1'b0;
      cmd        = '0;
      unique case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            cmd.load  = req_valid;
         end
         S_EXEC: begin
            cmd.commit = !stat.out_blocked;
         end
      endcase
   end

endmodule

// ===== hdl/sahl_dp.sv =====
// Datapath: request capture, bucket row RAM, valid bits, match and update, result register.
// Depends on sahl_pkg and sahl_ram.
`timescale 1ns / 1ps

module sahl_dp import sahl_pkg::*; #(
   parameter int BUCKET_BITS = 6,
   parameter int WAYS        = 4
) (
   input  logic                clock,
   input  logic                reset,
   input  dp_cmd_type          cmd,
   output dp_stat_type         stat,
   input  op_type              req_op,
   input  logic [COOKIE_W-1:0] req_initiator_cookie,
   input  logic [COOKIE_W-1:0] req_responder_cookie,
   input  logic [MID_W-1:0]    req_msg_id,
   input  logic                req_match_msg_id,
   input  logic [HANDLE_W-1:0] req_entry_handle,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output status_type          rsp_status,
   output logic [HANDLE_W-1:0] rsp_found_handle
);

   localparam int NUM_BUCKETS = 1 << BUCKET_BITS;
   localparam int ROW_W       = WAYS * ENTRY_W;

   // hash on the incoming request
   logic                   use_mid;
   logic [WORD_W-1:0]      fold;
   logic [BUCKET_BITS-1:0] bucket_in;

   assign use_mid   = (req_op != OP_LOOKUP) || req_match_msg_id;
   assign fold      = fold_key(req_initiator_cookie, req_responder_cookie,
                               req_msg_id, use_mid);
   assign bucket_in = fold[BUCKET_BITS-1:0];

   // captured request
   op_type                 op_ff;
   logic [COOKIE_W-1:0]    ic_ff;
   logic [COOKIE_W-1:0]    rc_ff;
   logic [MID_W-1:0]       mid_ff;
   logic                   match_ff;
   logic [HANDLE_W-1:0]    handle_ff;
   logic [BUCKET_BITS-1:0] bucket_ff;

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         op_ff     <= req_op;
         ic_ff     <= req_initiator_cookie;
         rc_ff     <= req_responder_cookie;
         mid_ff    <= req_msg_id;
         match_ff  <= req_match_msg_id;
         handle_ff <= req_entry_handle;
         bucket_ff <= bucket_in;
      end
   end

   // bucket row store
   entry_type [WAYS-1:0] row_rd;
   entry_type [WAYS-1:0] row_wr;
   logic                 row_we;

   sahl_ram #(
      .WIDTH (ROW_W),
      .DEPTH (NUM_BUCKETS)
   ) u_row_ram (
      .clock   (clock),
      .wr_en   (row_we),
      .wr_addr (bucket_ff),
      .wr_data (row_wr),
      .rd_en   (cmd.load),
      .rd_addr (bucket_in),
      .rd_data (row_rd)
   );

   // valid bits, one per slot; rows are kept compacted (newest at way 0)
   // row of valid bits is read at load, alongside the RAM row
   logic [WAYS-1:0] valid_ff [NUM_BUCKETS];
   logic [WAYS-1:0] vrow_ff;
   logic [WAYS-1:0] vrow;
   logic [WAYS-1:0] valid_in;

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         vrow_ff <= valid_ff[bucket_in];
      end
   end

   assign vrow = vrow_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int b = 0; b < NUM_BUCKETS; b++) begin
            valid_ff[b] <= '0;
         end
      end else if (row_we) begin
         valid_ff[bucket_ff] <= valid_in;
      end
   end

   // per-way compares
   logic [WAYS-1:0] ck_hit;
   logic [WAYS-1:0] lk_hit;
   logic [WAYS-1:0] rm_hit;

   always_comb begin
      for (int w = 0; w < WAYS; w++) begin
         ck_hit[w] = vrow[w] && (row_rd[w].initiator_cookie == ic_ff)
                     && (row_rd[w].responder_cookie == rc_ff);
         lk_hit[w] = ck_hit[w] && (match_ff ? (row_rd[w].msg_id == mid_ff)
                                            : (row_rd[w].msg_id == '0));
         rm_hit[w] = ck_hit[w] && (row_rd[w].msg_id == mid_ff)
                     && (row_rd[w].handle == handle_ff);
      end
   end

   // first match, newest first
   logic                seen_lk;
   logic                seen_rm;
   logic [WAYS-1:0]     lk_first;
   logic [WAYS-1:0]     rm_tail;   // ways at or after the removed one
   logic [HANDLE_W-1:0] lk_handle;

   always_comb begin
      seen_lk   = 1'b0;
      seen_rm   = 1'b0;
      lk_handle = '0;
      for (int w = 0; w < WAYS; w++) begin
         lk_first[w] = lk_hit[w] && !seen_lk;
         seen_lk     = seen_lk || lk_hit[w];
         seen_rm     = seen_rm || rm_hit[w];
         rm_tail[w]  = seen_rm;
         lk_handle   = lk_handle | (row_rd[w].handle & {HANDLE_W{lk_first[w]}});
      end
   end

   // new rows for insert (shift down) and remove (close the gap)
   entry_type [WAYS-1:0] ins_row;
   entry_type [WAYS-1:0] rm_row;
   entry_type            new_entry;
   logic [WAYS-1:0]      ins_v;
   logic [WAYS-1:0]      rm_v;

   assign new_entry = '{initiator_cookie: ic_ff, responder_cookie: rc_ff,
                        msg_id: mid_ff, handle: handle_ff};

   always_comb begin
      ins_row    = row_rd;
      ins_v      = vrow;
      ins_row[0] = new_entry;
      ins_v[0]   = 1'b1;
      for (int w = 1; w < WAYS; w++) begin
         ins_row[w] = row_rd[w-1];
         ins_v[w]   = vrow[w-1];
      end
      rm_row = row_rd;
      rm_v   = vrow;
      for (int w = 0; w < WAYS - 1; w++) begin
         if (rm_tail[w]) begin
            rm_row[w] = row_rd[w+1];
            rm_v[w]   = vrow[w+1];
         end
      end
      if (rm_tail[WAYS-1]) rm_v[WAYS-1] = 1'b0;
   end

   // result and write-back selection
   status_type          status_sel;
   logic [HANDLE_W-1:0] found_sel;
   logic                we_sel;

   always_comb begin
      status_sel = STATUS_NOT_FOUND;
      found_sel  = '0;
      we_sel     = 1'b0;
      row_wr     = ins_row;
      valid_in   = ins_v;
      unique case (op_ff)
         OP_INSERT: begin
            if (vrow[WAYS-1]) begin
               status_sel = STATUS_FULL;
            end else begin
               status_sel = STATUS_OK;
               we_sel     = 1'b1;
            end
         end
         OP_LOOKUP: begin
            if (seen_lk) begin
               status_sel = STATUS_OK;
               found_sel  = lk_handle;
            end
         end
         OP_REMOVE: begin
            row_wr   = rm_row;
            valid_in = rm_v;
            if (seen_rm) begin
               status_sel = STATUS_OK;
               we_sel     = 1'b1;
            end else begin
               status_sel = STATUS_ABSENT;
            end
         end
         default: begin
            status_sel = STATUS_NOT_FOUND;
         end
      endcase
   end

   assign row_we = cmd.commit && we_sel;

   // result register
   logic                rsp_valid_ff;
   logic                rsp_valid_in;
   status_type          rsp_status_ff;
   logic [HANDLE_W-1:0] rsp_handle_ff;

   assign rsp_valid_in = cmd.commit || (rsp_valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      if (cmd.commit) begin
         rsp_status_ff <= status_sel;
         rsp_handle_ff <= found_sel;
      end
   end

   assign stat.out_blocked = rsp_valid_ff && !rsp_ready;
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_status       = rsp_status_ff;
   assign rsp_found_handle = rsp_handle_ff;

endmodule

// ===== hdl/sa_hash_table_lookup_unit.sv =====
// SA hash table lookup unit: one request in, one response out per item.
// Timing: the bucket row read registers at the accepting edge; compare and write back follow in the
// execute state, and the response is registered when the item commits. The accept/execute controller
// keeps one item in flight, so no new request is taken until the last one commits; an untaken response holds it.
// Reset: synchronous, active high; clears slot valid bits at once, no clearing pass.
`timescale 1ns / 1ps

module sa_hash_table_lookup_unit import sahl_pkg::*; #(
   parameter int BUCKET_BITS = 6,   // log2 of bucket count
   parameter int WAYS        = 4    // slots per bucket
) (
   input  logic          clock,
   input  logic          reset,
   sahl_req_if.sink      req_ch,
   sahl_rsp_if.source    rsp_ch
);

   // Control and datapath talk only through these two structs.
   dp_cmd_type  cmd;
   dp_stat_type stat;
   logic        req_ready;

   // Controller: idle accepts a request (starting the row read), exec commits once the
   // result register is free. A waiting response does not block acceptance.
   sahl_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ready),
      .cmd       (cmd),
      .stat      (stat)
   );

   assign req_ch.ready = req_ready;

   // Datapath: hash, bucket RAM, valid bits, way compares, row shift, result register.
   sahl_dp #(
      .BUCKET_BITS (BUCKET_BITS),
      .WAYS        (WAYS)
   ) u_dp (
      .clock                (clock),
      .reset                (reset),
      .cmd                  (cmd),
      .stat                 (stat),
      .req_op               (req_ch.op),
      .req_initiator_cookie (req_ch.initiator_cookie),
      .req_responder_cookie (req_ch.responder_cookie),
      .req_msg_id           (req_ch.msg_id),
      .req_match_msg_id     (req_ch.match_msg_id),
      .req_entry_handle     (req_ch.entry_handle),
      .rsp_valid            (rsp_ch.valid),
      .rsp_ready            (rsp_ch.ready),
      .rsp_status           (rsp_ch.status),
      .rsp_found_handle     (rsp_ch.found_handle)
   );

`ifndef NO_ASSERTIONS
   // one item in flight: an accept is never followed directly by another
   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      (req_ch.valid && req_ch.ready) |=> !req_ch.ready)
      else $error("request accepted while previous item still executing");

   // never overwrite a response that has not been taken
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.commit |-> !(rsp_ch.valid && !rsp_ch.ready))
      else $error("commit while result register is blocked");

   // every commit shows up as a response next cycle
   a_commit_shows: assert property (@(posedge clock) disable iff (reset)
      cmd.commit |=> rsp_ch.valid)
      else $error("committed item did not produce a response");

   // a taken response with no new commit leaves the output empty
   a_no_phantom: assert property (@(posedge clock) disable iff (reset)
      (rsp_ch.valid && rsp_ch.ready && !cmd.commit) |=> !rsp_ch.valid)
      else $error("response repeated after being taken");
`endif

endmodule
